>>> hdl/hsvq_pkg.sv
// Shared widths, constants and hue sector codes for the HSV to RGB converter.
package hsvq_pkg;

  localparam int IN_W     = 17;
  localparam int OUT_W    = 8;
  localparam int BYTE_MAX = 255;

  // One sector per sixth of a turn, named by the dominant/secondary pair
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

>>> hdl/hsvq_rmul.sv
// Fixed-point multiplier with round-to-nearest on the dropped fraction bits.
module hsvq_rmul #(
  parameter int A_W  = 17,
  parameter int B_W  = 17,
  parameter int P_W  = 17,
  parameter int FRAC = 16
) (
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic [P_W-1:0] p
);

  localparam int SUM_W = A_W + B_W + 1;

  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] half;
  logic [SUM_W-1:0] sum;

  always_comb begin
    prod = SUM_W'(a) * SUM_W'(b);
    half = SUM_W'(1) << (FRAC - 1);
    sum  = prod + half;
    p    = P_W'(sum >> FRAC);
  end

endmodule

>>> hdl/hsv_to_rgb_q16.sv
// HSV to RGB colour converter, five-stage pipeline, one colour per clock while the output is taken.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in_     | input     | in_valid/in_ready   | in_hue, in_saturation, in_brightness
//   out_    | output    | out_valid/out_ready | out_red, out_green, out_blue
//
// Throughput is one colour per clock while the output is taken; the two rounded
// multipliers each own a stage.
// Synchronous active-low reset empties the pipeline; payload registers are not reset.
// Each stage holds when its successor is full and stalled, so an empty stage
// absorbs a new transaction even while the output waits to be taken.
module hsv_to_rgb_q16
  import hsvq_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_hue,
  input  logic [IN_W-1:0]  in_saturation,
  input  logic [IN_W-1:0]  in_brightness,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_red,
  output logic [OUT_W-1:0] out_green,
  output logic [OUT_W-1:0] out_blue
);

  localparam int NS  = 5;
  localparam int FW  = FRAC_BITS + 1;
  localparam int SW  = (FRAC_BITS + 1 < IN_W) ? FRAC_BITS + 1 : IN_W;
  localparam int HW  = (FRAC_BITS < IN_W) ? FRAC_BITS : IN_W;
  localparam int H6W = HW + 3;
  localparam int CW  = (FW > IN_W) ? FW : IN_W;
  localparam int EW  = (FW > H6W) ? FW : H6W;
  localparam int PW  = SW + OUT_W;

  // Stage valids and ready chain
  logic [NS-1:0] vld_r;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];

  // Stage 1: clamp saturation and value, wrap hue and scale it by six
  logic [CW-1:0]  one_cw;
  logic [CW-1:0]  s_ext;
  logic [CW-1:0]  v_ext;
  logic [CW-1:0]  s_lim;
  logic [CW-1:0]  v_lim;
  logic [HW-1:0]  h_wrap;
  logic [SW-1:0]  s1_nxt, s1_r;
  logic [SW-1:0]  v1_nxt, v1_r;
  logic [H6W-1:0] h6_1_nxt, h6_1_r;

  always_comb begin
    one_cw   = CW'(1) << FRAC_BITS;
    s_ext    = CW'(in_saturation);
    v_ext    = CW'(in_brightness);
    s_lim    = (s_ext > one_cw) ? one_cw : s_ext;
    v_lim    = (v_ext > one_cw) ? one_cw : v_ext;
    h_wrap   = in_hue[HW-1:0];
    s1_nxt   = s_lim[SW-1:0];
    v1_nxt   = v_lim[SW-1:0];
    h6_1_nxt = H6W'({h_wrap, 1'b0}) + H6W'({h_wrap, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_r   <= s1_nxt;
      v1_r   <= v1_nxt;
      h6_1_r <= h6_1_nxt;
    end
  end

  // Stage 2: chroma, sector and the triangle weight for the secondary
  logic [EW-1:0] h6_ext;
  logic [FW-1:0] t_frac;
  logic [SW-1:0] c2_nxt, c2_r;
  logic [SW-1:0] v2_r;
  logic [FW-1:0] f2_nxt, f2_r;
  logic [2:0]    sec2_nxt, sec2_r;

  hsvq_rmul #(
    .A_W  (SW),
    .B_W  (SW),
    .P_W  (SW),
    .FRAC (FRAC_BITS)
  ) u_chroma_mul (
    .a (v1_r),
    .b (s1_r),
    .p (c2_nxt)
  );

  always_comb begin
    h6_ext   = EW'(h6_1_r);
    t_frac   = h6_ext[FW-1:0];
    // Odd sector counts down from one, even sector counts up from zero
    f2_nxt   = t_frac[FRAC_BITS] ? (FW'(0) - t_frac) : t_frac;
    sec2_nxt = 3'(h6_1_r >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c2_r   <= c2_nxt;
      v2_r   <= v1_r;
      f2_r   <= f2_nxt;
      sec2_r <= sec2_nxt;
    end
  end

  // Stage 3: secondary component and offset
  logic [SW-1:0] x3_nxt, x3_r;
  logic [SW-1:0] c3_r;
  logic [SW-1:0] m3_nxt, m3_r;
  logic [2:0]    sec3_r;

  hsvq_rmul #(
    .A_W  (SW),
    .B_W  (FW),
    .P_W  (SW),
    .FRAC (FRAC_BITS)
  ) u_second_mul (
    .a (c2_r),
    .b (f2_r),
    .p (x3_nxt)
  );

  assign m3_nxt = v2_r - c2_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      x3_r   <= x3_nxt;
      c3_r   <= c2_r;
      m3_r   <= m3_nxt;
      sec3_r <= sec2_r;
    end
  end

  // Stage 4: place chroma and secondary by sector, add the offset
  logic [SW-1:0] r_sel, g_sel, b_sel;
  logic [SW-1:0] r4_nxt, r4_r;
  logic [SW-1:0] g4_nxt, g4_r;
  logic [SW-1:0] b4_nxt, b4_r;

  always_comb begin
    r_sel = '0;
    g_sel = '0;
    b_sel = '0;
    case (sector_t'(sec3_r))
      SEC_RED_YEL: begin r_sel = c3_r; g_sel = x3_r; end
      SEC_YEL_GRN: begin r_sel = x3_r; g_sel = c3_r; end
      SEC_GRN_CYN: begin g_sel = c3_r; b_sel = x3_r; end
      SEC_CYN_BLU: begin g_sel = x3_r; b_sel = c3_r; end
      SEC_BLU_MAG: begin r_sel = x3_r; b_sel = c3_r; end
      SEC_MAG_RED: begin r_sel = c3_r; b_sel = x3_r; end
      default: begin
        r_sel = '0;
        g_sel = '0;
        b_sel = '0;
      end
    endcase
    r4_nxt = r_sel + m3_r;
    g4_nxt = g_sel + m3_r;
    b4_nxt = b_sel + m3_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      r4_r <= r4_nxt;
      g4_r <= g4_nxt;
      b4_r <= b4_nxt;
    end
  end

  // Stage 5: scale to a byte, times full scale then drop the fraction
  logic [PW-1:0]    r_scl, g_scl, b_scl;
  logic [OUT_W-1:0] red_nxt, red_r;
  logic [OUT_W-1:0] green_nxt, green_r;
  logic [OUT_W-1:0] blue_nxt, blue_r;

  always_comb begin
    r_scl     = PW'(r4_r) * PW'(BYTE_MAX);
    g_scl     = PW'(g4_r) * PW'(BYTE_MAX);
    b_scl     = PW'(b4_r) * PW'(BYTE_MAX);
    red_nxt   = OUT_W'(r_scl >> FRAC_BITS);
    green_nxt = OUT_W'(g_scl >> FRAC_BITS);
    blue_nxt  = OUT_W'(b_scl >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

`ifndef SYNTHESIS
  a_empty_out_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipeline refused a transaction with an empty output stage");

  a_chroma_le_value : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (c2_r <= v2_r))
    else $error("chroma exceeds value");

  a_second_le_chroma : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (x3_r <= c3_r))
    else $error("secondary component exceeds chroma");

  a_stall_holds_stage : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !rdy[3] |=> vld_r[3] && $stable(r4_r) && $stable(g4_r) && $stable(b4_r))
    else $error("stalled stage lost its transaction");
`endif

endmodule
